// ----- hw/rtl/five_number_summary_tukey_core_defines.svh -----
// ----------------------------------------------------------------------------
// five number summary core: assertion macros
// implication forms used by the rtl, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef FIVE_NUMBER_SUMMARY_TUKEY_CORE_DEFINES_SVH
`define FIVE_NUMBER_SUMMARY_TUKEY_CORE_DEFINES_SVH
`ifndef SYNTH
`define FNST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FNST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FNST_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FNST_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/fnst_pkg.sv -----
// ----------------------------------------------------------------------------
// fnst_pkg
// shared types and constants of the five number summary core
// ----------------------------------------------------------------------------
package fnst_pkg;

  localparam int SAMPLE_W = 32;
  localparam int HINGE_W  = 34;
  localparam int MEAN_W   = 40;

  // rank selector slots
  localparam int N_RANKS  = 8;
  localparam int RK_MIN   = 0;
  localparam int RK_LO_A  = 1;
  localparam int RK_LO_B  = 2;
  localparam int RK_MED_A = 3;
  localparam int RK_MED_B = 4;
  localparam int RK_UP_A  = 5;
  localparam int RK_UP_B  = 6;
  localparam int RK_MAX   = 7;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP_MAG,
    B_PREP_NUM,
    B_SCAN,
    B_DRAIN,
    B_UPDATE,
    B_FINISH
  } back_state_t;

endpackage

// ----- hw/rtl/fnst_if.sv -----
// ----------------------------------------------------------------------------
// fnst channel interfaces
// sample input, summary output and mode register write channels
// ----------------------------------------------------------------------------
interface fnst_in_if;
  logic                      valid;
  logic                      ready;
  logic [fnst_pkg::SAMPLE_W-1:0] sample;
  logic                      has_sample;
  logic                      last;
  modport source (output valid, sample, has_sample, last, input ready);
  modport sink   (input valid, sample, has_sample, last, output ready);
endinterface

interface fnst_out_if #(parameter int CW = 11);
  logic                              valid;
  logic                              ready;
  logic [fnst_pkg::SAMPLE_W-1:0]     min_value;
  logic signed [fnst_pkg::HINGE_W-1:0] lower_hinge_x2;
  logic signed [fnst_pkg::HINGE_W-1:0] median_x2;
  logic signed [fnst_pkg::HINGE_W-1:0] upper_hinge_x2;
  logic [fnst_pkg::SAMPLE_W-1:0]     max_value;
  logic signed [fnst_pkg::MEAN_W-1:0]  mean_x100;
  logic [CW-1:0]                     sample_count;
  logic                              overflowed;
  modport source (output valid, min_value, lower_hinge_x2, median_x2, upper_hinge_x2,
                  max_value, mean_x100, sample_count, overflowed, input ready);
  modport sink   (input valid, min_value, lower_hinge_x2, median_x2, upper_hinge_x2,
                  max_value, mean_x100, sample_count, overflowed, output ready);
endinterface

interface fnst_cfg_if;
  logic valid;
  logic ready;
  logic signed_mode;
  modport source (output valid, signed_mode, input ready);
  modport sink   (input valid, signed_mode, output ready);
endinterface

// ----- hw/rtl/five_number_summary_tukey_core.sv -----
// throughput: samples are taken one item per cycle while a set loads
// after the closing item the set runs 32 radix passes over the kept samples through the single
// read port of the store; an empty set skips them and is held by the mean divider instead
// input stalls from the closing item until the result is in the output register
// reset: synchronous on rst; no store clearing pass, the store is never read unwritten
// ----------------------------------------------------------------------------
// five_number_summary_tukey_core
// min, tukey hinges, median, max, mean x100 and count of a set of samples
// ----------------------------------------------------------------------------
module five_number_summary_tukey_core #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  fnst_in_if.sink     in_ch,
  fnst_out_if.source  out_ch,
  fnst_cfg_if.sink    cfg
);
  import fnst_pkg::*;

  // store address, count and raw sum widths follow the capacity
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int QW = 2 * CW + SW + 1;

  logic          signed_mode;

  // front to back: store write port and the close command
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          cmd_push;
  logic [QW-1:0] cmd_in;
  logic          cmd_room;
  logic          cmd_pop;
  logic          cmd_valid;
  logic [QW-1:0] cmd_out;
  logic          set_done;

  // mode register, always ready; only write it while the core is idle (not enforced by the core)
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst)            signed_mode <= 1'b0;
    else if (cfg.valid) signed_mode <= cfg.signed_mode;
  end

  // front: loads samples, keeps count, raw sum, count of sign-set words, drop flag
  fnst_front #(
    .MAX_SAMPLES (MAX_SAMPLES), .AW (AW), .CW (CW), .SW (SW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_room (cmd_room),
    .set_done (set_done)
  );

  // close commands wait here until the back is free
  fnst_queue #(.W (QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .not_full  (cmd_room),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .pop_data  (cmd_out)
  );

  // back: holds the store, selects the eight ranks bit by bit, divides for the mean
  fnst_back #(
    .MAX_SAMPLES (MAX_SAMPLES), .AW (AW), .CW (CW), .SW (SW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .signed_mode (signed_mode),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_data    (cmd_out),
    .cmd_pop     (cmd_pop),
    .set_done    (set_done),
    .out_ch      (out_ch)
  );
endmodule

// ----- hw/rtl/fnst_div.sv -----
// ----------------------------------------------------------------------------
// fnst_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fnst_div #(
  parameter int NW = 51,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);
  localparam int SW = $clog2(NW + 1);

  logic [SW-1:0] step;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, quot[NW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= SW'(NW);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == SW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[NW-2:0], ge};
      rem  <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
    end
  end
endmodule

// ----- hw/rtl/fnst_queue.sv -----
// ----------------------------------------------------------------------------
// fnst_queue
// two entry command queue between front and back
// ----------------------------------------------------------------------------
module fnst_queue #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;

  assign not_full  = fill != 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= push_data;
  end
endmodule

// ----- hw/rtl/fnst_front.sv -----
// ----------------------------------------------------------------------------
// fnst_front
// takes sample items, writes the store, keeps count, sum and drop flag
// ----------------------------------------------------------------------------
module fnst_front #(
  parameter int MAX_SAMPLES = 1024,
  parameter int AW = 10,
  parameter int CW = 11,
  parameter int SW = 43
) (
  input  logic                clk,
  input  logic                rst,
  fnst_in_if.sink             in_ch,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [31:0]         wr_data,
  output logic                cmd_push,
  output logic [2*CW+SW:0]    cmd_data,
  input  logic                cmd_room,
  input  logic                set_done
);
  import fnst_pkg::*;

  logic          busy;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] raw_sum, raw_sum_next;
  logic [CW-1:0] neg_count, neg_count_next;
  logic          dropped, dropped_next;
  logic          acc;
  logic          keep;

  assign in_ch.ready = !busy && cmd_room;
  assign acc  = in_ch.valid && in_ch.ready;
  assign keep = in_ch.has_sample && (count < CW'(MAX_SAMPLES));

  assign wr_en   = acc && keep;
  assign wr_addr = count[AW-1:0];
  assign wr_data = in_ch.sample;

  always_comb begin
    count_next     = count + CW'(keep);
    raw_sum_next   = raw_sum + (keep ? SW'(in_ch.sample) : '0);
    neg_count_next = neg_count + CW'(keep && in_ch.sample[SAMPLE_W-1]);
    dropped_next   = dropped || (in_ch.has_sample && !keep);
  end

  assign cmd_push = acc && in_ch.last;
  assign cmd_data = {dropped_next, neg_count_next, raw_sum_next, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      raw_sum   <= '0;
      neg_count <= '0;
      dropped   <= 1'b0;
    end else begin
      if (set_done) busy <= 1'b0;
      if (acc) begin
        if (in_ch.last) begin
          busy      <= 1'b1;
          count     <= '0;
          raw_sum   <= '0;
          neg_count <= '0;
          dropped   <= 1'b0;
        end else begin
          count     <= count_next;
          raw_sum   <= raw_sum_next;
          neg_count <= neg_count_next;
          dropped   <= dropped_next;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/fnst_back.sv -----
// ----------------------------------------------------------------------------
// fnst_back
// radix selection of eight ranks over the store, mean division, result register
// ----------------------------------------------------------------------------
`include "five_number_summary_tukey_core_defines.svh"

module fnst_back #(
  parameter int MAX_SAMPLES = 1024,
  parameter int AW = 10,
  parameter int CW = 11,
  parameter int SW = 43
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             signed_mode,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [31:0]      wr_data,
  input  logic             cmd_valid,
  input  logic [2*CW+SW:0] cmd_data,
  output logic             cmd_pop,
  output logic             set_done,
  fnst_out_if.source       out_ch
);
  import fnst_pkg::*;

  localparam int NW = SW + 8;
  localparam int DW = CW + 1;

  back_state_t state, state_next;

  logic [31:0]       mem [MAX_SAMPLES];
  logic [31:0]       rd_data;
  logic              rd_vld;
  logic              rd_en;
  logic [AW-1:0]     addr;

  logic [CW-1:0]     n;
  logic [CW-1:0]     half;
  logic signed [SW:0] sum_s;
  logic              neg;
  logic [SW-1:0]     mag;
  logic              dropped;

  logic [CW-1:0]     rank   [N_RANKS];
  logic [31:0]       prefix [N_RANKS];
  logic [CW-1:0]     cnt    [N_RANKS];
  logic [31:0]       sel;
  logic [31:0]       mask;
  logic [31:0]       key;
  logic [31:0]       bias;

  logic              div_start;
  logic              div_busy;
  logic [NW-1:0]     quot;
  logic              out_free;
  logic              finish;

  // half-slice ranks for the hinges
  logic [CW-1:0] lo_mid, up_lo, up_mid, med_a, lo_a, up_a;

  assign bias     = {signed_mode, 31'b0};
  assign key      = rd_data ^ bias;
  assign rd_en    = state == B_SCAN;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign finish   = (state == B_FINISH) && !div_busy && out_free;
  assign cmd_pop  = (state == B_IDLE) && cmd_valid;
  assign div_start = state == B_PREP_NUM;
  assign set_done = finish;

  // store, written by the front, read here one word a cycle during the scan
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (cmd_valid) state_next = B_PREP_MAG;
      B_PREP_MAG: state_next = B_PREP_NUM;
      B_PREP_NUM: state_next = (n == '0) ? B_FINISH : B_SCAN;
      B_SCAN:     if (CW'(addr) == n - 1'b1) state_next = B_DRAIN;
      B_DRAIN:    state_next = B_UPDATE;
      B_UPDATE:   state_next = sel[0] ? B_FINISH : B_SCAN;
      B_FINISH:   if (finish) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    half   = cmd_data[CW-1:0] >> 1;
    lo_mid = half >> 1;
    up_lo  = half + CW'(cmd_data[0]);
    up_mid = up_lo + (half >> 1);
    med_a  = cmd_data[0] ? half : half - 1'b1;
    lo_a   = half[0] ? lo_mid : lo_mid - 1'b1;
    up_a   = half[0] ? up_mid : up_mid - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_vld <= 1'b0;
    else     rd_vld <= rd_en;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          n       <= cmd_data[CW-1:0];
          dropped <= cmd_data[2*CW+SW];
          sum_s   <= $signed({1'b0, cmd_data[CW+SW-1:CW]})
                     - (signed_mode ? $signed({1'b0, cmd_data[2*CW+SW-1:CW+SW], 32'b0})
                                    : $signed((SW+1)'(0)));
          rank[RK_MIN]   <= '0;
          rank[RK_LO_A]  <= lo_a;
          rank[RK_LO_B]  <= lo_mid;
          rank[RK_MED_A] <= med_a;
          rank[RK_MED_B] <= half;
          rank[RK_UP_A]  <= up_a;
          rank[RK_UP_B]  <= up_mid;
          rank[RK_MAX]   <= cmd_data[CW-1:0] - 1'b1;
        end
        for (int u = 0; u < N_RANKS; u++) begin
          prefix[u] <= '0;
          cnt[u]    <= '0;
        end
        sel  <= 32'h8000_0000;
        mask <= '0;
        addr <= '0;
      end
      B_PREP_MAG: begin
        neg <= sum_s < 0;
        mag <= SW'(sum_s < 0 ? -sum_s : sum_s);
      end
      B_SCAN: addr <= addr + 1'b1;
      B_UPDATE: begin
        for (int u = 0; u < N_RANKS; u++) begin
          if (rank[u] >= cnt[u]) begin
            prefix[u] <= prefix[u] | sel;
            rank[u]   <= rank[u] - cnt[u];
          end
          cnt[u] <= '0;
        end
        mask <= mask | sel;
        sel  <= sel >> 1;
        addr <= '0;
      end
      default: ;
    endcase
    // count words under the current prefix with a zero in the bit under test
    if (rd_vld) begin
      for (int u = 0; u < N_RANKS; u++) begin
        if ((((key ^ prefix[u]) & mask) == '0) && ((key & sel) == '0))
          cnt[u] <= cnt[u] + 1'b1;
      end
    end
  end

  fnst_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ((NW'(mag) << 7) + (NW'(mag) << 6) + (NW'(mag) << 3) + NW'(n)),
    .den   ({n, 1'b0}),
    .busy  (div_busy),
    .quot  (quot)
  );

  function automatic logic signed [HINGE_W-1:0] pair_x2(input logic [31:0] a,
                                                       input logic [31:0] b,
                                                       input logic        sm);
    logic [HINGE_W-1:0] s;
    s = {2'b0, a} + {2'b0, b} - (sm ? {2'b01, 32'b0} : '0);
    return $signed(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (finish) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch.sample_count <= n;
      out_ch.overflowed   <= dropped;
      if (n == '0) begin
        out_ch.min_value      <= '0;
        out_ch.max_value      <= '0;
        out_ch.median_x2      <= '0;
        out_ch.lower_hinge_x2 <= '0;
        out_ch.upper_hinge_x2 <= '0;
        out_ch.mean_x100      <= '0;
      end else begin
        out_ch.min_value <= prefix[RK_MIN] ^ bias;
        out_ch.max_value <= prefix[RK_MAX] ^ bias;
        out_ch.median_x2 <= pair_x2(prefix[RK_MED_A], prefix[RK_MED_B], signed_mode);
        if (n[CW-1:1] == '0) begin
          out_ch.lower_hinge_x2 <= '0;
          out_ch.upper_hinge_x2 <= '0;
        end else begin
          out_ch.lower_hinge_x2 <= pair_x2(prefix[RK_LO_A], prefix[RK_LO_B], signed_mode);
          out_ch.upper_hinge_x2 <= pair_x2(prefix[RK_UP_A], prefix[RK_UP_B], signed_mode);
        end
        out_ch.mean_x100 <= neg ? -$signed(quot[MEAN_W-1:0]) : $signed(quot[MEAN_W-1:0]);
      end
    end
  end

  `FNST_ASSERT_IMP(a_scan_in_range, clk, rst, (state == B_SCAN), (CW'(addr) < n))
  `FNST_ASSERT_IMP(a_div_idle, clk, rst, (state == B_IDLE), (!div_busy))
  `FNST_ASSERT_NXT(a_done_loads, clk, rst, (set_done), (out_ch.valid && state == B_IDLE))
endmodule
